>>> hdl/iee_pkg.sv
`default_nettype none
package iee_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned VALUE_DEPTH_DEF = 32;
  localparam int unsigned OP_DEPTH_DEF    = 32;

  // operator stack codes
  typedef enum logic [2:0] {
    OPC_LPAR = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_MUL  = 3'd3,
    OPC_DIV  = 3'd4
  } opc_e;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // handshake between sequencer and divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic op_rank(input opc_e opc);
    return (opc == OPC_MUL) || (opc == OPC_DIV);
  endfunction

endpackage
`default_nettype wire

>>> hdl/infix_expression_evaluator_top.sv
`default_nettype none
// channel   dir  tdata fields (lsb first)              extra
// s_axis    in   char_code[7:0]                        tlast = last
// m_axis    out  value[31:0], status[33:32], 0 pad     -
//
// a digit passes S_CHAR and S_FIN, a space or '(' also S_DISP, an operator or ')' also
// S_DISP, S_OPWAIT, S_OPCHK; each reduction adds S_VWAIT to S_OPCHK, a division S_DIV
// (radix-2); the last character adds S_ENDCL to S_OUT and the closing reductions, fewer
// after an error; s_axis_tready_o is high only in the idle state, one character at a time
// a finished result waits in the output register; a second result waits for it
// async active-low reset; stack contents need no clearing, counts do
module infix_expression_evaluator_top #(
  parameter int unsigned VALUE_DEPTH = iee_pkg::VALUE_DEPTH_DEF,
  parameter int unsigned OP_DEPTH    = iee_pkg::OP_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // char_code[7:0]
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // value[31:0], status[33:32], zeros
);
  import iee_pkg::*;

  localparam int unsigned VCW = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned VAW = $clog2(VALUE_DEPTH);
  localparam int unsigned OCW = $clog2(OP_DEPTH + 1);
  localparam int unsigned OAW = $clog2(OP_DEPTH);

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CHAR    = 13'b0000000000010,
    S_DISP    = 13'b0000000000100,
    S_OPWAIT  = 13'b0000000001000,
    S_OPCHK   = 13'b0000000010000,
    S_VWAIT   = 13'b0000000100000,
    S_EXEC    = 13'b0000001000000,
    S_DIV     = 13'b0000010000000,
    S_PUSHR   = 13'b0000100000000,
    S_FIN     = 13'b0001000000000,
    S_ENDCL   = 13'b0010000000000,
    S_OUTPREP = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // stacks
  logic [DATA_W-1:0] val_mem [VALUE_DEPTH];
  opc_e              op_mem  [OP_DEPTH];

  logic [VCW-1:0]    vc_q, vc_d;
  logic [OCW-1:0]    oc_q, oc_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              innum_q, innum_d;
  logic [STATUS_W-1:0] err_q, err_d;
  logic              bot_wr_q, bot_wr_d;    // bottom operator entry written
  logic              endph_q, endph_d;      // closing the outer parenthesis
  logic              close_q, close_d;      // running a ')' rather than an operator
  opc_e              newop_q, newop_d;
  logic [CHAR_W-1:0] ch_q;
  logic              last_q;
  logic [DATA_W-1:0] res_q, res_d;
  logic              ovalid_q, ovalid_d;
  logic [DATA_W-1:0] oval_q, oval_d;
  logic [STATUS_W-1:0] ostat_q, ostat_d;

  // registered stack reads
  logic [DATA_W-1:0] vb_q, va_q;
  opc_e              optop_raw_q;
  logic              optop_bot_q;
  opc_e              optop;
  logic [VAW-1:0]    vb_addr, va_addr;
  logic [OAW-1:0]    op_addr;

  // write ports
  logic              val_we, op_we;
  logic [DATA_W-1:0] val_wd;
  opc_e              op_wd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              take_in;
  logic              is_digit, has_op;
  logic [DATA_W-1:0] digit;

  iee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign vb_addr = vc_q[VAW-1:0] - VAW'(1);
  assign va_addr = vc_q[VAW-1:0] - VAW'(2);
  assign op_addr = oc_q[OAW-1:0] - OAW'(1);

  always_ff @(posedge clk_i) begin
    vb_q        <= val_mem[vb_addr];
    va_q        <= val_mem[va_addr];
    optop_raw_q <= op_mem[op_addr];
    optop_bot_q <= (op_addr == '0) && !bot_wr_q;
    if (val_we) begin
      val_mem[vc_q[VAW-1:0]] <= val_wd;
    end
    if (op_we) begin
      op_mem[oc_q[OAW-1:0]] <= op_wd;
    end
  end

  // bottom entry reads as '(' until first written after a restart
  assign optop = optop_bot_q ? OPC_LPAR : optop_raw_q;

  assign take_in  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign digit    = DATA_W'(ch_q - CH_ZERO);
  assign has_op   = (oc_q != '0) && (optop != OPC_LPAR);

  always_comb begin
    state_d  = state_q;
    vc_d     = vc_q;
    oc_d     = oc_q;
    acc_d    = acc_q;
    innum_d  = innum_q;
    err_d    = err_q;
    bot_wr_d = bot_wr_q;
    endph_d  = endph_q;
    close_d  = close_q;
    newop_d  = newop_q;
    res_d    = res_q;
    ovalid_d = ovalid_q;
    oval_d   = oval_q;
    ostat_d  = ostat_q;
    val_we   = 1'b0;
    val_wd   = acc_q;
    op_we    = 1'b0;
    op_wd    = OPC_LPAR;
    div_req.start    = 1'b0;
    div_req.dividend = va_q;
    div_req.divisor  = vb_q;

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (take_in) begin
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        if (err_q != ST_OK) begin
          state_d = S_FIN;
        end else if (is_digit) begin
          acc_d   = {acc_q[DATA_W-4:0], 3'b000} + {acc_q[DATA_W-2:0], 1'b0} + digit;
          innum_d = 1'b1;
          state_d = S_FIN;
        end else begin
          // any other character ends the number in progress
          if (innum_q) begin
            if (vc_q >= VCW'(VALUE_DEPTH)) begin
              err_d = ST_OVERFLOW;
            end else begin
              val_we = 1'b1;
              vc_d   = vc_q + VCW'(1);
            end
            acc_d   = '0;
            innum_d = 1'b0;
          end
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_OPWAIT;
        close_d = 1'b0;
        if (err_q != ST_OK) begin
          state_d = S_FIN;
        end else begin
          unique case (ch_q)
            CH_SPACE: state_d = S_FIN;
            CH_LPAR: begin
              if (oc_q >= OCW'(OP_DEPTH)) begin
                err_d = ST_OVERFLOW;
              end else begin
                op_we = 1'b1;
                op_wd = OPC_LPAR;
                oc_d  = oc_q + OCW'(1);
                if (oc_q == '0) bot_wr_d = 1'b1;
              end
              state_d = S_FIN;
            end
            CH_RPAR: close_d = 1'b1;
            CH_ADD:  newop_d = OPC_ADD;
            CH_SUB:  newop_d = OPC_SUB;
            CH_MUL:  newop_d = OPC_MUL;
            CH_DIV:  newop_d = OPC_DIV;
            default: begin
              err_d   = ST_MALFORMED;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_OPWAIT: begin
        state_d = S_OPCHK;
      end
      S_OPCHK: begin
        state_d = endph_q ? S_OUTPREP : S_FIN;
        if (close_q) begin
          if (has_op) begin
            state_d = S_VWAIT;
          end else if (oc_q == '0) begin
            err_d = ST_MALFORMED;
          end else begin
            oc_d = oc_q - OCW'(1);
          end
        end else begin
          if (has_op && (op_rank(newop_q) <= op_rank(optop))) begin
            state_d = S_VWAIT;
          end else if (oc_q >= OCW'(OP_DEPTH)) begin
            err_d = ST_OVERFLOW;
          end else begin
            op_we = 1'b1;
            op_wd = newop_q;
            oc_d  = oc_q + OCW'(1);
            if (oc_q == '0) bot_wr_d = 1'b1;
          end
        end
      end
      S_VWAIT: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // reduce: pop one operator and two values
        state_d = endph_q ? S_OUTPREP : S_FIN;
        if (vc_q < VCW'(2)) begin
          err_d = ST_MALFORMED;
        end else if ((optop == OPC_DIV) && (vb_q == '0)) begin
          err_d = ST_DIVZERO;
        end else begin
          oc_d = oc_q - OCW'(1);
          vc_d = vc_q - VCW'(2);
          unique case (optop)
            OPC_ADD: begin
              res_d   = va_q + vb_q;
              state_d = S_PUSHR;
            end
            OPC_SUB: begin
              res_d   = va_q - vb_q;
              state_d = S_PUSHR;
            end
            OPC_MUL: begin
              res_d   = DATA_W'(va_q * vb_q);
              state_d = S_PUSHR;
            end
            default: begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quotient;
          state_d = S_PUSHR;
        end
      end
      S_PUSHR: begin
        val_wd = res_q;
        if (vc_q >= VCW'(VALUE_DEPTH)) begin
          err_d   = ST_OVERFLOW;
          state_d = endph_q ? S_OUTPREP : S_FIN;
        end else begin
          val_we  = 1'b1;
          vc_d    = vc_q + VCW'(1);
          state_d = S_OPWAIT;
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          endph_d = 1'b1;
          state_d = S_OUTPREP;
          if (err_q == ST_OK) begin
            state_d = S_ENDCL;
            if (innum_q) begin
              if (vc_q >= VCW'(VALUE_DEPTH)) begin
                err_d = ST_OVERFLOW;
              end else begin
                val_we = 1'b1;
                vc_d   = vc_q + VCW'(1);
              end
              acc_d   = '0;
              innum_d = 1'b0;
            end
          end
        end
      end
      S_ENDCL: begin
        // close the implicit outer parenthesis
        close_d = 1'b1;
        state_d = (err_q == ST_OK) ? S_OPWAIT : S_OUTPREP;
      end
      S_OUTPREP: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          oval_d   = ((err_q == ST_OK) && (vc_q != '0)) ? vb_q : '0;
          ostat_d  = err_q;
          vc_d     = '0;
          oc_d     = OCW'(1);
          acc_d    = '0;
          innum_d  = 1'b0;
          err_d    = ST_OK;
          bot_wr_d = 1'b0;
          endph_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vc_q     <= '0;
      oc_q     <= OCW'(1);
      acc_q    <= '0;
      innum_q  <= 1'b0;
      err_q    <= ST_OK;
      bot_wr_q <= 1'b0;
      endph_q  <= 1'b0;
      close_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vc_q     <= vc_d;
      oc_q     <= oc_d;
      acc_q    <= acc_d;
      innum_q  <= innum_d;
      err_q    <= err_d;
      bot_wr_q <= bot_wr_d;
      endph_q  <= endph_d;
      close_q  <= close_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    newop_q <= newop_d;
    res_q   <= res_d;
    oval_q  <= oval_d;
    ostat_q <= ostat_d;
    if (take_in) begin
      ch_q   <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'b0, ostat_q, oval_q};

endmodule
`default_nettype wire

>>> hdl/iee_div.sv
`default_nettype none
module iee_div (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  iee_pkg::div_req_t    req_i,
  output iee_pkg::div_rsp_t    rsp_o
);
  import iee_pkg::*;

  localparam int unsigned CW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [DATA_W:0]   shifted, diff;

  // one quotient bit per cycle on magnitudes
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
      dvs_d  = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      cnt_d  = CW'(DATA_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

>>> verif/infix_expression_evaluator_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module infix_expression_evaluator_top_tb;
  import iee_pkg::*;

  localparam int unsigned VDEPTH = VALUE_DEPTH_DEF;
  localparam int unsigned ODEPTH = OP_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  // scoreboard: evaluates the expression as characters go in, holds answers
  class expr_scoreboard;
    logic [DATA_W-1:0] vals[VDEPTH];
    opc_e              ops[ODEPTH];
    int unsigned       nvals, nops;
    logic [DATA_W-1:0] acc;
    bit                in_num;
    logic [STATUS_W-1:0] err;
    answer_t           pending[$];
    int unsigned       mismatches;

    function void clear();
      nvals = 0; nops = 1; ops[0] = OPC_LPAR;
      acc = '0; in_num = 0; err = ST_OK;
    endfunction

    function void raise(logic [STATUS_W-1:0] e);
      if (err == ST_OK) err = e;
    endfunction

    function void push_val(logic [DATA_W-1:0] v);
      if (nvals >= VDEPTH) raise(ST_OVERFLOW);
      else begin
        vals[nvals] = v; nvals++;
      end
    endfunction

    function void push_op(opc_e o);
      if (nops >= ODEPTH) raise(ST_OVERFLOW);
      else begin
        ops[nops] = o; nops++;
      end
    endfunction

    function void end_number();
      if (in_num) begin
        push_val(acc); acc = '0; in_num = 0;
      end
    endfunction

    function bit heavy(opc_e o);
      return (o == OPC_MUL) || (o == OPC_DIV);
    endfunction

    function bit reduce();
      opc_e o;
      logic [DATA_W-1:0] a, b, r, ma, mb;
      o = ops[nops-1];
      if (nvals < 2) begin
        raise(ST_MALFORMED); return 0;
      end
      b = vals[nvals-1]; a = vals[nvals-2];
      if (o == OPC_DIV && b == 0) begin
        raise(ST_DIVZERO); return 0;
      end
      nops--; nvals -= 2;
      case (o)
        OPC_ADD: r = a + b;
        OPC_SUB: r = a - b;
        OPC_MUL: r = a * b;
        default: begin
          ma = a[DATA_W-1] ? -a : a;
          mb = b[DATA_W-1] ? -b : b;
          r = ma / mb;
          if (a[DATA_W-1] ^ b[DATA_W-1]) r = -r;
        end
      endcase
      push_val(r);
      return 1;
    endfunction

    function void close_group();
      while (nops > 0 && ops[nops-1] != OPC_LPAR)
        if (!reduce()) return;
      if (nops == 0) begin
        raise(ST_MALFORMED); return;
      end
      nops--;
    endfunction

    function void binary(opc_e o);
      while (nops > 0 && ops[nops-1] != OPC_LPAR && heavy(o) <= heavy(ops[nops-1]))
        if (!reduce()) return;
      push_op(o);
    endfunction

    function void take(logic [CHAR_W-1:0] c);
      if (err != ST_OK) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = acc * 10 + (c - CH_ZERO); in_num = 1; return;
      end
      end_number();
      if (err != ST_OK) return;
      case (c)
        CH_SPACE: ;
        CH_LPAR:  push_op(OPC_LPAR);
        CH_RPAR:  close_group();
        CH_ADD:   binary(OPC_ADD);
        CH_SUB:   binary(OPC_SUB);
        CH_MUL:   binary(OPC_MUL);
        CH_DIV:   binary(OPC_DIV);
        default:  raise(ST_MALFORMED);
      endcase
    endfunction

    // note one accepted character
    function void note_request(logic [CHAR_W-1:0] c, bit last);
      answer_t ans;
      take(c);
      if (!last) return;
      if (err == ST_OK) begin
        end_number();
        if (err == ST_OK) close_group();
      end
      ans.value = (err == ST_OK && nvals > 0) ? vals[nvals-1] : '0;
      ans.status = err;
      pending.push_back(ans);
      clear();
    endfunction

    function void check_result(logic [39:0] data);
      answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.value || data[33:32] !== want.status
          || data[39:34] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                   $signed(want.value), want.status, $signed(data[31:0]), data[33:32]);
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        s_axis_tvalid_i = 0, s_axis_tlast_i = 0, m_axis_tready_i = 0;
  logic [7:0]  s_axis_tdata_i = '0;
  wire         s_axis_tready_o, m_axis_tvalid_o;
  wire  [39:0] m_axis_tdata_o;

  infix_expression_evaluator_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  expr_scoreboard sb = new();
  int unsigned cycles;
  int unsigned burst_left;
  bit          stall_mode;

  // receiver: alternates between free flow and a random stall pattern
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    m_axis_tready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // send one character, with bursts and random gaps before it
  task automatic send_char(input logic [7:0] c, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1; s_axis_tdata_i <= c; s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(c, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // mostly well-formed random expression with occasional noise
  task automatic send_random_expr(inout int unsigned count);
    int unsigned terms, depth;
    logic [7:0] opch[4];
    opch = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};
    terms = $urandom_range(1, 8);
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        send_char(opch[$urandom_range(0, 3)], 0); count++;
      end
      while ($urandom_range(0, 3) == 0) begin
        send_char(CH_LPAR, 0); depth++; count++;
      end
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 3)) begin
        send_char(pick_digit(), 0); count++;
      end
      if ($urandom_range(0, 5) == 0) begin
        send_char(CH_SPACE, 0); count++;
      end
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        send_char(CH_RPAR, 0); depth--; count++;
      end
      if ($urandom_range(0, 29) == 0) begin
        send_char(8'($urandom_range(0, 255)), 0); count++;
      end
    end
    while (depth > 0 && $urandom_range(0, 3) != 0) begin
      send_char(CH_RPAR, 0); depth--; count++;
    end
    // final character: a digit, a close or something random
    case ($urandom_range(0, 4))
      0: send_char(8'($urandom_range(0, 255)), 1);
      1: send_char(CH_RPAR, 1);
      default: send_char(pick_digit(), 1);
    endcase
    count++;
  endtask

  initial begin
    int unsigned count;
    int unsigned wait_cycles;
    sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed cases
    send_text("12+3*4-(5-7)/2");
    send_text("1 2");
    send_text("4294967295+1");
    send_text("99999999999");
    send_text("7/0");
    send_text("-3");
    send_text("2)");
    send_text("1+a");
    send_text("(((1+2)");
    send_text("0-2147483647-1/1");
    send_text("(0-2147483647-1)/(0-1)");
    send_text("(0-7)/2*3");
    send_text("8/(0-3)");
    send_text("1*2*3*4*5");
    send_text("\xff");
    send_text(" ");
    send_text("((((((((((((((((((((((((((((((((1");
    send_text("1+2+3+4+5+6+7+8+9+10+11+12+13+14+15+16+17+18+19+20+21+22+23+24+25+26+27+28+29+30+31+32+33");
    send_text("1+(2+(3+(4+(5+(6+(7+(8+(9+(10+(11+(12+(13+(14+(15+(16+(17+(18+(19+(20+(21+(22+(23+(24+(25+(26+(27+(28+(29+(30+(31+(32+33");
    // every char code, each standing alone
    for (int c = 0; c < 256; c++) send_char(8'(c), 1);

    // random expressions fill up to about 1550 characters in all
    count = 0;
    while (count < 930) send_random_expr(count);
    s_axis_tvalid_i <= 0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i); wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
